### rtl/conv2d_pkg.sv
`timescale 1ns / 1ps
// Shared widths, types and constants of the 3x3 zero-padded convolution block.
package conv2d_pkg;

    localparam int KSIZE   = 3;
    localparam int PIX_W   = 16;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = PIX_W + COEF_W + 1;
    localparam int CSUM_W  = PROD_W + 2;
    localparam int TSUM_W  = CSUM_W + 2;
    localparam int VALUE_W = 23;
    localparam int ROW_W   = 16;
    localparam int OUTX_W  = 11;

    typedef logic [KSIZE-1:0][PIX_W-1:0]  pix_col_t;
    typedef logic [KSIZE-1:0][COEF_W-1:0] coef_col_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic sum_en;
    } cell_ctrl_t;

endpackage

### rtl/conv2d_line_buf.sv
`timescale 1ns / 1ps
// Two line stores holding the two previous rows, with a read-modify-write bypass.
module conv2d_line_buf
    import conv2d_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic [PIX_W-1:0]             wr_pix,
    input  logic                         wb_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wb_addr,
    output logic [PIX_W-1:0]             up1,
    output logic [PIX_W-1:0]             up2
);

    logic [PIX_W-1:0] mem_a [MAX_WIDTH];
    logic [PIX_W-1:0] mem_b [MAX_WIDTH];

    logic [PIX_W-1:0] up1_reg;
    logic [PIX_W-1:0] up2_rd_reg;
    logic [PIX_W-1:0] fwd_data_reg;
    logic             fwd_reg;
    logic             fwd_next;

    // The older line store is written when the item leaves the first stage; a read
    // of the same column in that cycle takes the value being written instead.
    assign fwd_next = rd_en && wb_en && (rd_addr == wb_addr);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            up1_reg     <= mem_a[rd_addr];
            up2_rd_reg  <= mem_b[rd_addr];
            mem_a[rd_addr] <= wr_pix;
            fwd_data_reg <= up1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wb_en) begin
            mem_b[wb_addr] <= up1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= fwd_next;
        end
    end

    assign up1 = up1_reg;
    assign up2 = fwd_reg ? fwd_data_reg : up2_rd_reg;

endmodule

### rtl/conv2d_cell.sv
`timescale 1ns / 1ps
// One window column cell: holds three pixels, forms three products and their sum.
module conv2d_cell
    import conv2d_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cell_ctrl_t               ctrl,
    input  pix_col_t                 col_in,
    input  coef_col_t                coef,
    input  logic [KSIZE-1:0]         tap_en,
    output pix_col_t                 col_out,
    output logic signed [CSUM_W-1:0] csum
);

    pix_col_t                 col_reg;
    logic signed [PROD_W-1:0] prod_reg [KSIZE];
    logic signed [PROD_W-1:0] prod_next [KSIZE];
    logic signed [CSUM_W-1:0] csum_reg;
    logic signed [CSUM_W-1:0] csum_next;

    always_comb begin
        for (int r = 0; r < KSIZE; r++) begin
            prod_next[r] = tap_en[r]
                ? PROD_W'($signed({1'b0, col_in[r]}) * $signed(coef[r]))
                : '0;
        end
    end

    always_comb begin
        csum_next = '0;
        for (int r = 0; r < KSIZE; r++) begin
            csum_next = csum_next + CSUM_W'(prod_reg[r]);
        end
    end

    // The window empties after the final item of a frame has been shifted in.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (ctrl.shift) begin
            col_reg <= ctrl.clear ? '0 : col_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            for (int r = 0; r < KSIZE; r++) begin
                prod_reg[r] <= prod_next[r];
            end
        end
        if (ctrl.sum_en) begin
            csum_reg <= csum_next;
        end
    end

    assign col_out = col_reg;
    assign csum    = csum_reg;

endmodule

### rtl/conv2d_3x3_zero_pad_top.sv
`timescale 1ns / 1ps
// Each result passes the line store read, window cells, total sum and output register; the
// pixel that completes its window is one row plus one pixel after the result's own pixel.
// One transfer per cycle when not stalled; the five-stage pipeline closes bubbles under stall.
// Reset clears counters, window, pipeline valids and loads 512x512 and a kernel passing the left
// neighbour at unit weight; the line stores are not cleared, since out-of-frame taps are masked.
module conv2d_3x3_zero_pad_top
    import conv2d_pkg::*;
#(
    parameter int MAX_WIDTH      = 2048,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [5:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_opcode,
    input  logic [PIX_W-1:0]     s_pixel,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [VALUE_W-1:0]   m_value,
    output logic [OUTX_W-1:0]    m_out_x,
    output logic [ROW_W-1:0]     m_out_y,
    output logic                 m_last_of_frame
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int WW  = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
    localparam int CW  = WW + 1;
    localparam int HW  = ROW_W + 1;

    localparam logic [2:0] REG_COEF_TOP = 3'd0;
    localparam logic [2:0] REG_COEF_MID = 3'd1;
    localparam logic [2:0] REG_COEF_BOT = 3'd2;
    localparam logic [2:0] REG_WIDTH    = 3'd3;
    localparam logic [2:0] REG_HEIGHT   = 3'd4;

    localparam logic [ROW_W-1:0]       ROW_MAX   = '1;
    localparam logic [TSUM_W-1:0]      ROUND_ADD = TSUM_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic [TSUM_W-1:0]      VALUE_MAX = {{(TSUM_W-VALUE_W){1'b0}}, {VALUE_W{1'b1}}};

    // ---------------- configuration registers ----------------
    logic [KSIZE-1:0][3*COEF_W-1:0] coef_reg;
    logic [11:0]                    width_reg;
    logic [ROW_W-1:0]               height_reg;
    logic [2:0]                     reg_idx;
    logic                           cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg[0] <= '0;
            coef_reg[1] <= (3*COEF_W)'(4096);
            coef_reg[2] <= '0;
            width_reg   <= 12'd512;
            height_reg  <= 16'd512;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_COEF_TOP: coef_reg[0] <= pwdata[3*COEF_W-1:0];
                REG_COEF_MID: coef_reg[1] <= pwdata[3*COEF_W-1:0];
                REG_COEF_BOT: coef_reg[2] <= pwdata[3*COEF_W-1:0];
                REG_WIDTH:    width_reg   <= pwdata[11:0];
                REG_HEIGHT:   height_reg  <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_COEF_TOP: prdata = 64'(coef_reg[0]);
            REG_COEF_MID: prdata = 64'(coef_reg[1]);
            REG_COEF_BOT: prdata = 64'(coef_reg[2]);
            REG_WIDTH:    prdata = 64'(width_reg);
            REG_HEIGHT:   prdata = 64'(height_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------- effective frame geometry ----------------
    logic [CW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb begin
        w_eff = CW'(width_reg);
        if (w_eff == '0) begin
            w_eff = CW'(1);
        end else if (w_eff > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end
        h_eff = (height_reg == '0) ? HW'(1) : HW'(height_reg);
    end

    // ---------------- pipeline flow control ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic emit1_reg, emit2_reg;
    logic free_o, free_4, free_3, free_2, free_1;
    logic mv4, mv3, mv2, mv1;
    logic acc, take;

    assign free_o  = !vo_reg || m_ready;
    assign mv4     = v4_reg && free_o;
    assign free_4  = !v4_reg || mv4;
    assign mv3     = v3_reg && free_4;
    assign free_3  = !v3_reg || mv3;
    // Items that give no result leave the pipeline once they have shifted the window.
    assign mv2     = v2_reg && (!emit2_reg || free_3);
    assign free_2  = !v2_reg || mv2;
    assign mv1     = v1_reg && free_2;
    assign free_1  = !v1_reg || mv1;
    assign s_ready = free_1;
    assign acc     = s_valid && s_ready;

    // ---------------- input-side control state ----------------
    logic [AW-1:0]    in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [AW-1:0]    out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic             fd_reg, fd_next;

    logic [CW-1:0]    in_col_p1, out_col_p1, out_col_x;
    logic [HW-1:0]    in_row_p1, out_row_p1, out_row_x;
    logic             wrap_col, emit, last, out_wrap;
    logic [PIX_W-1:0] pix_in;
    logic [KSIZE-1:0] row_ok, col_ok;

    // A drain step before the frame is complete is accepted and dropped.
    assign take   = acc && (fd_reg || !s_opcode);
    assign pix_in = fd_reg ? '0 : s_pixel;

    always_comb begin
        in_col_p1  = CW'(in_col_reg) + CW'(1);
        in_row_p1  = HW'(in_row_reg) + HW'(1);
        out_col_x  = CW'(out_col_reg);
        out_col_p1 = out_col_x + CW'(1);
        out_row_x  = HW'(out_row_reg);
        out_row_p1 = out_row_x + HW'(1);

        wrap_col = in_col_p1 >= w_eff;
        emit     = (in_row_reg >= ROW_W'(2)) || (in_row_reg == ROW_W'(1) && in_col_reg != '0);
        out_wrap = out_col_p1 >= w_eff;
        last     = emit && out_wrap && (out_row_p1 >= h_eff);

        row_ok[0] = (out_row_reg != '0) && (out_row_x <= h_eff);
        row_ok[1] = out_row_x < h_eff;
        row_ok[2] = out_row_p1 < h_eff;
        col_ok[0] = (out_col_reg != '0) && (out_col_x <= w_eff);
        col_ok[1] = out_col_x < w_eff;
        col_ok[2] = out_col_p1 < w_eff;

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        fd_next      = fd_reg;
        if (last) begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            fd_next      = 1'b0;
        end else begin
            if (wrap_col) begin
                in_col_next = '0;
                if (in_row_reg != ROW_MAX) begin
                    in_row_next = in_row_p1[ROW_W-1:0];
                end
                if (in_row_p1 >= h_eff) begin
                    fd_next = 1'b1;
                end
            end else begin
                in_col_next = in_col_p1[AW-1:0];
            end
            if (emit) begin
                if (out_wrap) begin
                    out_col_next = '0;
                    out_row_next = out_row_p1[ROW_W-1:0];
                end else begin
                    out_col_next = out_col_p1[AW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            fd_reg      <= 1'b0;
        end else if (take) begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            fd_reg      <= fd_next;
        end
    end

    // ---------------- stage 1: line store read ----------------
    logic [AW-1:0]     addr1_reg;
    logic [PIX_W-1:0]  pix1_reg;
    logic              last1_reg;
    logic [OUTX_W-1:0] x1_reg;
    logic [ROW_W-1:0]  y1_reg;
    logic [KSIZE-1:0]  row_ok1_reg, col_ok1_reg;
    logic [PIX_W-1:0]  up1, up2;

    conv2d_line_buf #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (take),
        .rd_addr (in_col_reg),
        .wr_pix  (pix_in),
        .wb_en   (mv1),
        .wb_addr (addr1_reg),
        .up1     (up1),
        .up2     (up2)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (free_1) begin
            v1_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            addr1_reg   <= in_col_reg;
            pix1_reg    <= pix_in;
            emit1_reg   <= emit;
            last1_reg   <= last;
            x1_reg      <= OUTX_W'(out_col_reg);
            y1_reg      <= out_row_reg;
            row_ok1_reg <= row_ok;
            col_ok1_reg <= col_ok;
        end
    end

    // ---------------- stages 2 and 3: window cells ----------------
    cell_ctrl_t                      cell_ctrl;
    pix_col_t                        new_col;
    pix_col_t                        col_out [KSIZE];
    logic signed [CSUM_W-1:0]        csum    [KSIZE];
    logic                            last2_reg, last3_reg;
    logic [OUTX_W-1:0]               x2_reg, x3_reg;
    logic [ROW_W-1:0]                y2_reg, y3_reg;

    assign cell_ctrl.shift  = mv1;
    assign cell_ctrl.clear  = last1_reg;
    assign cell_ctrl.sum_en = mv2 && emit2_reg;

    assign new_col[0] = up2;
    assign new_col[1] = up1;
    assign new_col[2] = pix1_reg;

    for (genvar k = 0; k < KSIZE; k++) begin : g_cell
        coef_col_t        coef_k;
        pix_col_t         col_in_k;
        logic [KSIZE-1:0] tap_en_k;

        for (genvar r = 0; r < KSIZE; r++) begin : g_tap
            assign coef_k[r]   = coef_reg[r][COEF_W*k +: COEF_W];
            assign tap_en_k[r] = row_ok1_reg[r] && col_ok1_reg[k];
        end

        if (k == KSIZE - 1) begin : g_head
            assign col_in_k = new_col;
        end else begin : g_link
            assign col_in_k = col_out[k+1];
        end

        conv2d_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (cell_ctrl),
            .col_in  (col_in_k),
            .coef    (coef_k),
            .tap_en  (tap_en_k),
            .col_out (col_out[k]),
            .csum    (csum[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (free_2) begin
                v2_reg <= mv1;
            end
            if (free_3) begin
                v3_reg <= mv2 && emit2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mv1) begin
            emit2_reg <= emit1_reg;
            last2_reg <= last1_reg;
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
        end
        if (mv2 && emit2_reg) begin
            last3_reg <= last2_reg;
            x3_reg    <= x2_reg;
            y3_reg    <= y2_reg;
        end
    end

    // ---------------- stage 4: total sum ----------------
    logic signed [TSUM_W-1:0] tsum_reg;
    logic                     last4_reg;
    logic [OUTX_W-1:0]        x4_reg;
    logic [ROW_W-1:0]         y4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (free_4) begin
            v4_reg <= mv3;
        end
    end

    always_ff @(posedge aclk) begin
        if (mv3) begin
            tsum_reg  <= TSUM_W'(csum[0]) + TSUM_W'(csum[1]) + TSUM_W'(csum[2]);
            last4_reg <= last3_reg;
            x4_reg    <= x3_reg;
            y4_reg    <= y3_reg;
        end
    end

    // ---------------- output register: round half up, clamp ----------------
    logic [TSUM_W-1:0]  rnd_sum;
    logic [TSUM_W-1:0]  rnd_shift;
    logic [VALUE_W-1:0] value_next;

    always_comb begin
        rnd_sum   = {1'b0, tsum_reg[TSUM_W-2:0]} + ROUND_ADD;
        rnd_shift = rnd_sum >> COEF_FRAC_BITS;
        priority if (tsum_reg[TSUM_W-1]) begin
            value_next = '0;
        end else if (rnd_shift > VALUE_MAX) begin
            value_next = '1;
        end else begin
            value_next = rnd_shift[VALUE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (free_o) begin
            vo_reg <= mv4;
        end
    end

    always_ff @(posedge aclk) begin
        if (mv4) begin
            m_value         <= value_next;
            m_out_x         <= x4_reg;
            m_out_y         <= y4_reg;
            m_last_of_frame <= last4_reg;
        end
    end

    assign m_valid = vo_reg;

endmodule

### verif/conv2d_checker.sv
`timescale 1ns / 1ps
// Register map and opcodes of the convolution testbench, and the checker that predicts results.
package conv2d_tb_pkg;

    typedef enum logic [5:0] {
        REG_COEF_TOP = 6'd0,
        REG_COEF_MID = 6'd8,
        REG_COEF_BOT = 6'd16,
        REG_WIDTH    = 6'd24,
        REG_HEIGHT   = 6'd32
    } conv_reg_e;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } conv_op_e;

endpackage

module conv2d_checker
    import conv2d_pkg::*;
    import conv2d_tb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_opcode,
    input  logic [PIX_W-1:0]   s_pixel,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [VALUE_W-1:0] m_value,
    input  logic [OUTX_W-1:0]  m_out_x,
    input  logic [ROW_W-1:0]   m_out_y,
    input  logic               m_last_of_frame,
    output int                 mismatches,
    output int                 pending,
    output bit                 frame_complete
);

    localparam int     LINE_DEPTH = 2048;
    localparam int     FRAC_BITS  = 12;
    localparam longint VALUE_MAX  = (longint'(1) << VALUE_W) - 1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [OUTX_W-1:0]  x;
        logic [ROW_W-1:0]   y;
        logic               last;
    } conv_result_t;

    conv_result_t results_due[$];
    conv_result_t seen;
    conv_result_t want;

    logic [47:0]      coef_row [3];
    logic [11:0]      width_cfg;
    logic [15:0]      height_cfg;
    logic [PIX_W-1:0] newest_row [LINE_DEPTH];
    logic [PIX_W-1:0] older_row  [LINE_DEPTH];
    logic [PIX_W-1:0] tap [9];
    longint           col_in, row_in, col_out, row_out;
    bit               frame_full;

    function automatic void restart_frame();
        int k;
        for (k = 0; k < 9; k++) tap[k] = '0;
        col_in = 0;
        row_in = 0;
        col_out = 0;
        row_out = 0;
        frame_full = 1'b0;
    endfunction

    function automatic void reset_model();
        int i;
        coef_row[0] = '0;
        coef_row[1] = 48'd4096;
        coef_row[2] = '0;
        width_cfg = 12'd512;
        height_cfg = 16'd512;
        for (i = 0; i < LINE_DEPTH; i++) begin
            newest_row[i] = '0;
            older_row[i] = '0;
        end
        restart_frame();
        results_due.delete();
    endfunction

    // Advances the window by one accepted item and queues the result it causes, if any.
    function automatic void convolve_item(input logic op, input logic [PIX_W-1:0] pix_in);
        longint           w, h, c, iy, ix, acc;
        logic [PIX_W-1:0] pix, up1, up2;
        bit               emit, last;
        int               ky, kx;
        conv_result_t     r;
        w = width_cfg;
        if (w == 0) w = 1;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        h = height_cfg;
        if (h == 0) h = 1;
        // A drain before the frame is complete is dropped without effect.
        if (!frame_full && op == OP_DRAIN) return;
        pix = frame_full ? '0 : pix_in;

        c = (col_in < LINE_DEPTH) ? col_in : LINE_DEPTH - 1;
        up2 = older_row[c];
        up1 = newest_row[c];
        older_row[c] = up1;
        newest_row[c] = pix;
        for (ky = 0; ky < 3; ky++) begin
            tap[ky*3]   = tap[ky*3+1];
            tap[ky*3+1] = tap[ky*3+2];
        end
        tap[2] = up2;
        tap[5] = up1;
        tap[8] = pix;

        emit = row_in >= 2 || (row_in == 1 && col_in >= 1);
        if (!frame_full && col_in + 1 >= w && row_in + 1 >= h) frame_full = 1'b1;
        if (col_in + 1 >= w) begin
            col_in = 0;
            if (row_in < 65535) row_in++;
        end else begin
            col_in++;
        end
        if (!emit) return;

        // Taps that fall outside the frame contribute nothing.
        acc = 0;
        for (ky = 0; ky < 3; ky++) begin
            iy = row_out + ky - 1;
            if (iy >= 0 && iy < h) begin
                for (kx = 0; kx < 3; kx++) begin
                    ix = col_out + kx - 1;
                    if (ix >= 0 && ix < w)
                        acc += longint'($signed(coef_row[ky][16*kx +: 16]))
                             * longint'(tap[ky*3+kx]);
                end
            end
        end
        if (acc < 0) begin
            r.value = '0;
        end else begin
            acc = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            r.value = (acc > VALUE_MAX) ? VALUE_MAX[VALUE_W-1:0] : acc[VALUE_W-1:0];
        end
        last = col_out + 1 >= w && row_out + 1 >= h;
        r.x = col_out[OUTX_W-1:0];
        r.y = row_out[ROW_W-1:0];
        r.last = last;
        results_due.push_back(r);

        if (last) begin
            restart_frame();
        end else if (col_out + 1 >= w) begin
            col_out = 0;
            row_out++;
        end else begin
            col_out++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_model();
        end else begin
            if (m_valid && m_ready) begin
                seen = '{m_value, m_out_x, m_out_y, m_last_of_frame};
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result value=%0d x=%0d y=%0d last=%0b",
                                 $realtime, seen.value, seen.x, seen.y, seen.last);
                end else begin
                    want = results_due.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("%0t: mismatch, expected value=%0d x=%0d y=%0d last=%0b",
                                   $realtime, want.value, want.x, want.y, want.last);
                            $display(", got value=%0d x=%0d y=%0d last=%0b",
                                     seen.value, seen.x, seen.y, seen.last);
                        end
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    REG_COEF_TOP: coef_row[0] = pwdata[47:0];
                    REG_COEF_MID: coef_row[1] = pwdata[47:0];
                    REG_COEF_BOT: coef_row[2] = pwdata[47:0];
                    REG_WIDTH:    width_cfg   = pwdata[11:0];
                    REG_HEIGHT:   height_cfg  = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) convolve_item(s_opcode, s_pixel);
        end
        pending = results_due.size();
        frame_complete = frame_full;
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Top of the convolution testbench: clock, reset, stimulus, register writes and the verdict.
module tb
    import conv2d_pkg::*;
    import conv2d_tb_pkg::*;
();

    logic               aclk;
    logic               aresetn;
    logic               psel, penable, pwrite;
    logic [5:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;
    logic               s_valid, s_ready, s_opcode;
    logic [PIX_W-1:0]   s_pixel;
    logic               m_valid, m_ready;
    logic [VALUE_W-1:0] m_value;
    logic [OUTX_W-1:0]  m_out_x;
    logic [ROW_W-1:0]   m_out_y;
    logic               m_last_of_frame;

    int  mismatches;
    int  pending;
    bit  frame_complete;

    int          items_sent;
    int          burst_left;
    logic [11:0] width_now;
    logic [15:0] height_now;
    bit          hold_req;
    bit          hold_served;

    conv2d_3x3_zero_pad_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode), .s_pixel(s_pixel),
        .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value), .m_out_x(m_out_x),
        .m_out_y(m_out_y), .m_last_of_frame(m_last_of_frame)
    );

    conv2d_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode), .s_pixel(s_pixel),
        .m_valid(m_valid), .m_ready(m_ready), .m_value(m_value), .m_out_x(m_out_x),
        .m_out_y(m_out_y), .m_last_of_frame(m_last_of_frame),
        .mismatches(mismatches), .pending(pending), .frame_complete(frame_complete)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // The receiver switches between stall patterns; a requested hold-off overrides them.
    initial begin
        int mode, left, hold_left, cyc;
        m_ready = 1'b0;
        hold_served = 1'b0;
        mode = 0;
        left = 0;
        hold_left = 0;
        cyc = 0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                hold_left = 400;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            cyc++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                case (mode)
                    0: m_ready = 1'b1;
                    1: m_ready = 1'($urandom_range(0, 1));
                    2: m_ready = ($urandom_range(0, 3) == 0);
                    default: m_ready = (cyc % 3 != 0);
                endcase
            end
        end
    end

    task automatic write_reg(input conv_reg_e addr, input logic [63:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_geometry(input logic [11:0] w, input logic [15:0] h);
        write_reg(REG_WIDTH, {$urandom, 8'($urandom), 12'(w)});
        write_reg(REG_HEIGHT, {$urandom, 16'($urandom), h});
        width_now = w;
        height_now = h;
    endtask

    // Each tap is an extreme, zero, minus one LSB, a value within plus or minus unity or anything at all.
    function automatic logic [63:0] rand_coef_row();
        logic [63:0] r;
        int k;
        r = {$urandom, $urandom};
        for (k = 0; k < 3; k++) begin
            case ($urandom_range(0, 7))
                0: r[16*k +: 16] = 16'h7FFF;
                1: r[16*k +: 16] = 16'h8000;
                2: r[16*k +: 16] = 16'h0000;
                3: r[16*k +: 16] = 16'hFFFF;
                4, 5: r[16*k +: 16] = 16'($urandom_range(0, 8192) - 4096);
                default: r[16*k +: 16] = 16'($urandom);
            endcase
        end
        return r;
    endfunction

    task automatic load_kernel();
        write_reg(REG_COEF_TOP, rand_coef_row());
        write_reg(REG_COEF_MID, rand_coef_row());
        write_reg(REG_COEF_BOT, rand_coef_row());
    endtask

    function automatic int active_width();
        if (width_now == 0) return 1;
        if (width_now > 2048) return 2048;
        return int'(width_now);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input int style);
        case (style)
            1: case ($urandom_range(0, 2))
                   0: return '0;
                   1: return '1;
                   default: return PIX_W'($urandom);
               endcase
            2: return PIX_W'($urandom_range(0, 255));
            3: return PIX_W'($urandom_range(65280, 65535));
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Offers one item and returns at the falling edge after its transfer, valid left high.
    task automatic push(input conv_op_e op, input logic [PIX_W-1:0] px);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(100, 300);
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(1, 8);
            end
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_opcode = op;
        s_pixel = px;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stops offering until every predicted result has left the block and its pipeline is empty.
    task automatic wait_idle();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    // Retunes the block in the middle of a frame; the width never grows there.
    task automatic mid_frame_change();
        wait_idle();
        load_kernel();
        if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_HEIGHT, 64'($urandom_range(0, 8)));
            height_now = 16'($urandom_range(0, 8));
            write_reg(REG_HEIGHT, {48'd0, height_now});
        end
        if ($urandom_range(0, 2) == 0) begin
            width_now = 12'($urandom_range(0, active_width()));
            write_reg(REG_WIDTH, {52'd0, width_now});
        end
    endtask

    // Sends pixels until the frame is complete, then drains until the item yielding its last result is taken.
    task automatic send_frame(input int style, input bit retune);
        int n, pause_at, area;
        n = 0;
        area = active_width() * ((height_now == 0) ? 1 : int'(height_now));
        pause_at = (retune && area > 1) ? $urandom_range(1, area - 1) : -1;
        while (!frame_complete) begin
            if ($urandom_range(0, 24) == 0) push(OP_DRAIN, PIX_W'($urandom));
            if (n == pause_at) mid_frame_change();
            push(OP_PIXEL, pick_pixel(style));
            items_sent++;
            n++;
        end
        // Once the frame is complete any item drains, whatever its opcode.
        while (frame_complete) begin
            push(conv_op_e'($urandom_range(0, 1)), PIX_W'($urandom));
            items_sent++;
        end
    endtask

    initial begin
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_opcode = OP_PIXEL;
        s_pixel = '0;
        hold_req = 1'b0;
        burst_left = 0;
        items_sent = 0;
        width_now = 12'd512;
        height_now = 16'd512;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extreme coefficients and pixels on a 3x2 frame, led by a drain
        // that arrives before any frame has completed.
        set_geometry(12'd3, 16'd2);
        write_reg(REG_COEF_TOP, {16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        write_reg(REG_COEF_MID, {16'h0000, 16'hFFFF, 16'h0001, 16'h8000});
        write_reg(REG_COEF_BOT, {16'hA5A5, 16'h0000, 16'h0800, 16'h1000});
        push(OP_DRAIN, 16'hFFFF);
        send_frame(1, 1'b0);
        wait_idle();

        // Negative surround weights around a centre weight of two, on a 2x2 frame, let sums fall below zero and clamp.
        set_geometry(12'd2, 16'd2);
        write_reg(REG_COEF_TOP, {16'h0000, 16'hF800, 16'hF800, 16'hF800});
        write_reg(REG_COEF_MID, {16'h0000, 16'hF800, 16'h2000, 16'hF800});
        write_reg(REG_COEF_BOT, {16'h0000, 16'hF800, 16'hF800, 16'hF800});
        send_frame(1, 1'b0);
        wait_idle();

        // Zero width and height behave as a single pixel.
        set_geometry(12'd0, 16'd0);
        write_reg(REG_COEF_TOP, 64'd0);
        write_reg(REG_COEF_MID, 64'h0000_0000_1000_0000);
        write_reg(REG_COEF_BOT, 64'd0);
        send_frame(1, 1'b0);
        wait_idle();

        // The receiver holds off long enough for the block to back up its input.
        set_geometry(12'd40, 16'd10);
        load_kernel();
        hold_req = 1'b1;
        send_frame(0, 1'b0);

        items_sent = 0;
        while (items_sent < 750) begin
            wait_idle();
            if ($urandom_range(0, 1) == 0) load_kernel();
            case ($urandom_range(0, 9))
                0: width_now = 12'd0;
                8, 9: width_now = 12'($urandom_range(9, 40));
                default: width_now = 12'($urandom_range(1, 8));
            endcase
            height_now = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
            set_geometry(width_now, height_now);
            send_frame($urandom_range(0, 3), $urandom_range(0, 3) == 0);
        end

        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### conv2d_3x3_zero_pad_top.f
rtl/conv2d_pkg.sv
rtl/conv2d_line_buf.sv
rtl/conv2d_cell.sv
rtl/conv2d_3x3_zero_pad_top.sv
verif/conv2d_checker.sv
verif/tb.sv
